[hw/rtl/tdmcg_pkg.sv]
// Package for the TDM MIMO chirp generator: sizes, register indexes, stage types
// and the CORDIC rotation angle table. Depends on nothing; every other file uses it.
package tdmcg_pkg;

   localparam int PHASE_BITS      = 48;
   localparam int SAMPLE_BITS     = 16;
   localparam int MAX_CHANNELS    = 4;
   localparam int COUNT_BITS      = 16;
   localparam int CHAN_BITS       = 2;
   localparam int NCH_BITS        = 3;
   localparam int ANGLE_BITS      = 32;
   localparam int CW              = 34;
   localparam int ROT_STEPS       = 18;
   localparam int STEPS_PER_STAGE = 3;
   localparam int CORDIC_STAGES   = ROT_STEPS / STEPS_PER_STAGE;
   localparam int PIPE_DEPTH      = CORDIC_STAGES + 2;
   localparam int ROUND_SHIFT     = 30 - (SAMPLE_BITS - 1);
   localparam int CSR_INDEX_BITS  = 3;
   localparam int CSR_DATA_BITS   = 48;

   localparam logic [CW-1:0] X_INIT = CW'(652032874);

   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHANNEL_COUNT = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SLOT_SAMPLES  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHIRP_SAMPLES = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_PHASE   = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_FREQ    = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FREQ_STEP     = 3'd5;

   typedef struct packed {
      logic [NCH_BITS-1:0]   channel_count;
      logic [COUNT_BITS-1:0] slot_samples;
      logic [COUNT_BITS-1:0] chirp_samples;
      logic [PHASE_BITS-1:0] start_phase;
      logic [PHASE_BITS-1:0] start_freq;
      logic [PHASE_BITS-1:0] freq_step;
   } cfg_type;

   typedef struct packed {
      logic [CW-1:0] x;
      logic [CW-1:0] y;
      logic [CW-1:0] z;
   } rot_type;

   typedef struct packed {
      logic [CHAN_BITS-1:0] channel;
      logic                 in_chirp;
      logic                 frame_last;
      logic                 flip;
   } tag_type;

   // Rotation angles in units of 2^-32 turn.
   function automatic logic [CW-1:0] rot_angle(input int unsigned i);
      logic [CW-1:0] r;
      case (i)
         0:       r = CW'(32'h20000000);
         1:       r = CW'(32'h12E4051D);
         2:       r = CW'(32'h09FB385B);
         3:       r = CW'(32'h051111D4);
         4:       r = CW'(32'h028B0D43);
         5:       r = CW'(32'h0145D7E1);
         6:       r = CW'(32'h00A2F61E);
         7:       r = CW'(32'h00517C55);
         8:       r = CW'(32'h0028BE53);
         9:       r = CW'(32'h00145F2E);
         10:      r = CW'(32'h000A2F98);
         11:      r = CW'(32'h000517CC);
         12:      r = CW'(32'h00028BE6);
         13:      r = CW'(32'h000145F3);
         14:      r = CW'(32'h0000A2F9);
         15:      r = CW'(32'h0000517C);
         16:      r = CW'(32'h000028BE);
         17:      r = CW'(32'h0000145F);
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

[hw/rtl/tdm_mimo_chirp_generator_core.sv]
// TDM MIMO linear-FM chirp generator, top level: stream ports, register file, pipeline control.
// Depends on tdmcg_pkg, tdmcg_seq, tdmcg_rot and tdmcg_out.

// The block emits one complex sample per accepted request beat and sustains one beat per
// clock while no result waits at rsp. Each result shows up as a valid rsp beat out of the
// rounding register. The path has eight registers: one sequencer register, which loads
// at the accepting edge, six CORDIC stages of three rotations each, and the rounding
// register. That depth is set by the 18-step sine/cosine CORDIC. The whole pipeline
// moves as one: while a result waits at rsp with rsp_tready low, every stage holds and
// req_tready is low, and it accepts again in the same cycle the waiting result is taken.
// A request beat with restart set rewinds the frame to slot 0, sample 0 and reloads the
// accumulators before its sample is made. Registers written through the csr port take
// effect on the next request beat; start phase and frequency load at the next slot start
// or restart. There is no clearing pass after reset.
module tdm_mimo_chirp_generator_core (
   input  logic                                      clock,
   input  logic                                      reset,
   // Request: tdata bit 0 restart, bits 7:1 zero.
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   input  logic [7:0]                                req_tdata,
   // Response: tdata bits 15:0 sample_i, bits 31:16 sample_q.
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   output logic [2*tdmcg_pkg::SAMPLE_BITS-1:0]       rsp_tdata,
   // Response tuser: bits 1:0 active_channel, bit 2 in_chirp.
   output logic [tdmcg_pkg::CHAN_BITS:0]             rsp_tuser,
   output logic                                      rsp_tlast,
   // Register write channel.
   input  logic                                      csr_valid,
   output logic                                      csr_ready,
   input  logic [tdmcg_pkg::CSR_INDEX_BITS-1:0]      csr_index,
   input  logic [tdmcg_pkg::CSR_DATA_BITS-1:0]       csr_data
);

   tdmcg_pkg::cfg_type cfg_ff, cfg_in;
   logic [tdmcg_pkg::PIPE_DEPTH-1:0] valid_ff, valid_in;
   logic advance, accept;

   tdmcg_pkg::rot_type stage_rot [tdmcg_pkg::CORDIC_STAGES+1];
   tdmcg_pkg::tag_type stage_tag [tdmcg_pkg::CORDIC_STAGES+1];

   // The pipeline moves whenever the result register is empty or being drained.
   assign advance    = !valid_ff[tdmcg_pkg::PIPE_DEPTH-1] || rsp_tready;
   assign accept     = req_tvalid && advance;
   assign req_tready = advance;
   assign rsp_tvalid = valid_ff[tdmcg_pkg::PIPE_DEPTH-1];
   assign csr_ready  = 1'b1;
   assign valid_in   = {valid_ff[tdmcg_pkg::PIPE_DEPTH-2:0], accept};

   // Register file. Indexes past the last register are ignored.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            tdmcg_pkg::CSR_CHANNEL_COUNT: cfg_in.channel_count = csr_data[tdmcg_pkg::NCH_BITS-1:0];
            tdmcg_pkg::CSR_SLOT_SAMPLES:  cfg_in.slot_samples  = csr_data[tdmcg_pkg::COUNT_BITS-1:0];
            tdmcg_pkg::CSR_CHIRP_SAMPLES: cfg_in.chirp_samples = csr_data[tdmcg_pkg::COUNT_BITS-1:0];
            tdmcg_pkg::CSR_START_PHASE:   cfg_in.start_phase   = csr_data[tdmcg_pkg::PHASE_BITS-1:0];
            tdmcg_pkg::CSR_START_FREQ:    cfg_in.start_freq    = csr_data[tdmcg_pkg::PHASE_BITS-1:0];
            tdmcg_pkg::CSR_FREQ_STEP:     cfg_in.freq_step     = csr_data[tdmcg_pkg::PHASE_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channel_count <= tdmcg_pkg::NCH_BITS'(1);
         cfg_ff.slot_samples  <= tdmcg_pkg::COUNT_BITS'(1);
         cfg_ff.chirp_samples <= tdmcg_pkg::COUNT_BITS'(1);
         cfg_ff.start_phase   <= '0;
         cfg_ff.start_freq    <= '0;
         cfg_ff.freq_step     <= '0;
         valid_ff             <= '0;
      end else begin
         cfg_ff <= cfg_in;
         if (advance) begin
            valid_ff <= valid_in;
         end
      end
   end

   tdmcg_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .enable  (advance),
      .restart (req_tdata[0]),
      .cfg     (cfg_ff),
      .rot_ff  (stage_rot[0]),
      .tag_ff  (stage_tag[0])
   );

   for (genvar g = 0; g < tdmcg_pkg::CORDIC_STAGES; g++) begin : g_rot
      tdmcg_rot #(
         .FIRST (g * tdmcg_pkg::STEPS_PER_STAGE),
         .STEPS (tdmcg_pkg::STEPS_PER_STAGE)
      ) u_rot (
         .clock  (clock),
         .enable (advance),
         .rot_i  (stage_rot[g]),
         .tag_i  (stage_tag[g]),
         .rot_ff (stage_rot[g+1]),
         .tag_ff (stage_tag[g+1])
      );
   end

   tdmcg_out u_out (
      .clock   (clock),
      .enable  (advance),
      .rot_i   (stage_rot[tdmcg_pkg::CORDIC_STAGES]),
      .tag_i   (stage_tag[tdmcg_pkg::CORDIC_STAGES]),
      .data_ff (rsp_tdata),
      .user_ff (rsp_tuser),
      .last_ff (rsp_tlast)
   );

`ifndef SYNTHESIS
   // Samples outside the chirp must be exact zeros.
   a_zero_outside_chirp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[tdmcg_pkg::CHAN_BITS] |-> rsp_tdata == '0)
      else $error("nonzero sample outside chirp");

   // While the result waits, no stage may gain or lose an item.
   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(valid_ff))
      else $error("pipeline occupancy changed during stall");

   // A beat taken with the result register full and not drained would be lost.
   a_no_accept_when_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !accept)
      else $error("request accepted while pipeline stalled");
`endif

endmodule

[hw/rtl/tdmcg_seq.sv]
// Frame sequencer: sample and slot counters plus the phase and frequency accumulators.
// Feeds the first CORDIC stage register. Depends on tdmcg_pkg.
module tdmcg_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic                enable,
   input  logic                restart,
   input  tdmcg_pkg::cfg_type  cfg,
   output tdmcg_pkg::rot_type  rot_ff,
   output tdmcg_pkg::tag_type  tag_ff
);

   logic [tdmcg_pkg::COUNT_BITS-1:0] sample_index_ff, sample_index_in, idx, slen, slen_last;
   logic [tdmcg_pkg::CHAN_BITS-1:0]  slot_index_ff, slot_index_in, slot;
   logic [tdmcg_pkg::PHASE_BITS-1:0] phase_acc_ff, phase_acc_in, freq_acc_ff, freq_acc_in;
   logic [tdmcg_pkg::PHASE_BITS-1:0] ph, fr;
   logic [tdmcg_pkg::NCH_BITS-1:0]   nch, nch_last;
   logic [tdmcg_pkg::ANGLE_BITS-1:0] angle, angle_red;
   logic [tdmcg_pkg::CW-1:0]         z_start;
   logic                             chirp, slot_end, frame_end, flip;

   always_comb begin
      if (cfg.channel_count == '0) begin
         nch = tdmcg_pkg::NCH_BITS'(1);
      end else if (cfg.channel_count > tdmcg_pkg::NCH_BITS'(tdmcg_pkg::MAX_CHANNELS)) begin
         nch = tdmcg_pkg::NCH_BITS'(tdmcg_pkg::MAX_CHANNELS);
      end else begin
         nch = cfg.channel_count;
      end
      nch_last = nch - tdmcg_pkg::NCH_BITS'(1);
      slen = (cfg.slot_samples == '0) ? tdmcg_pkg::COUNT_BITS'(1) : cfg.slot_samples;
      slen_last = slen - tdmcg_pkg::COUNT_BITS'(1);

      // A restart acts as if the frame had just wrapped.
      idx  = restart ? '0 : sample_index_ff;
      slot = restart ? '0 : slot_index_ff;
      ph   = restart ? cfg.start_phase : phase_acc_ff;
      fr   = restart ? cfg.start_freq  : freq_acc_ff;

      chirp     = idx < cfg.chirp_samples;
      slot_end  = idx >= slen_last;
      frame_end = slot_end && ({1'b0, slot} >= nch_last);

      // Fold the second and third quadrants by half a turn; the outputs get negated.
      angle     = ph[tdmcg_pkg::PHASE_BITS-1 -: tdmcg_pkg::ANGLE_BITS];
      flip      = angle[tdmcg_pkg::ANGLE_BITS-1] ^ angle[tdmcg_pkg::ANGLE_BITS-2];
      angle_red = {angle[tdmcg_pkg::ANGLE_BITS-1] ^ flip, angle[tdmcg_pkg::ANGLE_BITS-2:0]};
      z_start   = {{(tdmcg_pkg::CW - tdmcg_pkg::ANGLE_BITS){angle_red[tdmcg_pkg::ANGLE_BITS-1]}},
                   angle_red};

      if (slot_end) begin
         sample_index_in = '0;
         slot_index_in   = frame_end ? '0 : slot + tdmcg_pkg::CHAN_BITS'(1);
         phase_acc_in    = cfg.start_phase;
         freq_acc_in     = cfg.start_freq;
      end else begin
         sample_index_in = idx + tdmcg_pkg::COUNT_BITS'(1);
         slot_index_in   = slot;
         phase_acc_in    = chirp ? ph + fr : ph;
         freq_acc_in     = chirp ? fr + cfg.freq_step : fr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_index_ff <= '0;
         slot_index_ff   <= '0;
         phase_acc_ff    <= '0;
         freq_acc_ff     <= '0;
      end else if (accept) begin
         sample_index_ff <= sample_index_in;
         slot_index_ff   <= slot_index_in;
         phase_acc_ff    <= phase_acc_in;
         freq_acc_ff     <= freq_acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rot_ff.x          <= tdmcg_pkg::X_INIT;
         rot_ff.y          <= '0;
         rot_ff.z          <= z_start;
         tag_ff.channel    <= slot;
         tag_ff.in_chirp   <= chirp;
         tag_ff.frame_last <= frame_end;
         tag_ff.flip       <= flip;
      end
   end

endmodule

[hw/rtl/tdmcg_rot.sv]
// One CORDIC pipeline stage running a few rotation steps in vectoring-free rotation mode.
// Depends on tdmcg_pkg for the word width and angle table.
module tdmcg_rot #(
   parameter int FIRST = 0,
   parameter int STEPS = 3
) (
   input  logic                clock,
   input  logic                enable,
   input  tdmcg_pkg::rot_type  rot_i,
   input  tdmcg_pkg::tag_type  tag_i,
   output tdmcg_pkg::rot_type  rot_ff,
   output tdmcg_pkg::tag_type  tag_ff
);

   tdmcg_pkg::rot_type rot_in;

   always_comb begin
      logic signed [tdmcg_pkg::CW-1:0] x, y, z, dx, dy;
      x = $signed(rot_i.x);
      y = $signed(rot_i.y);
      z = $signed(rot_i.z);
      for (int k = 0; k < STEPS; k++) begin
         dx = y >>> (FIRST + k);
         dy = x >>> (FIRST + k);
         if (!z[tdmcg_pkg::CW-1]) begin
            x = x - dx;
            y = y + dy;
            z = z - $signed(tdmcg_pkg::rot_angle(FIRST + k));
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + $signed(tdmcg_pkg::rot_angle(FIRST + k));
         end
      end
      rot_in.x = x;
      rot_in.y = y;
      rot_in.z = z;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rot_ff <= rot_in;
         tag_ff <= tag_i;
      end
   end

endmodule

[hw/rtl/tdmcg_out.sv]
// Output stage: quadrant unfold, rounding to Q1.15 and saturation into the result register.
// Depends on tdmcg_pkg.
module tdmcg_out (
   input  logic                                 clock,
   input  logic                                 enable,
   input  tdmcg_pkg::rot_type                   rot_i,
   input  tdmcg_pkg::tag_type                   tag_i,
   output logic [2*tdmcg_pkg::SAMPLE_BITS-1:0]  data_ff,
   output logic [tdmcg_pkg::CHAN_BITS:0]        user_ff,
   output logic                                 last_ff
);

   localparam logic [tdmcg_pkg::CW-1:0] ROUND_HALF =
      tdmcg_pkg::CW'(1) << (tdmcg_pkg::ROUND_SHIFT - 1);
   localparam logic [tdmcg_pkg::CW-1:0] SMP_MAX =
      (tdmcg_pkg::CW'(1) << (tdmcg_pkg::SAMPLE_BITS - 1)) - tdmcg_pkg::CW'(1);

   logic [tdmcg_pkg::SAMPLE_BITS-1:0] cos_val, sin_val;

   function automatic logic [tdmcg_pkg::SAMPLE_BITS-1:0] to_sample(
      input logic signed [tdmcg_pkg::CW-1:0] v,
      input logic                            neg
   );
      logic signed [tdmcg_pkg::CW-1:0] s, r;
      s = neg ? -v : v;
      r = (s + $signed(ROUND_HALF)) >>> tdmcg_pkg::ROUND_SHIFT;
      if (r > $signed(SMP_MAX)) begin
         r = $signed(SMP_MAX);
      end else if (r < -$signed(SMP_MAX) - 1) begin
         r = -$signed(SMP_MAX) - 1;
      end
      return r[tdmcg_pkg::SAMPLE_BITS-1:0];
   endfunction

   always_comb begin
      if (tag_i.in_chirp) begin
         cos_val = to_sample($signed(rot_i.x), tag_i.flip);
         sin_val = to_sample($signed(rot_i.y), tag_i.flip);
      end else begin
         cos_val = '0;
         sin_val = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= {sin_val, cos_val};
         user_ff <= {tag_i.in_chirp, tag_i.channel};
         last_ff <= tag_i.frame_last;
      end
   end

endmodule

[sim/tdm_mimo_chirp_generator_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the TDM MIMO chirp generator core.
// Needs tdmcg_pkg and the core RTL; predicts every sample with its own CORDIC model.
module tdm_mimo_chirp_generator_core_tb;
   import tdmcg_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int MAX_PRINTED = 60;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SPARE_HI = 3'd7;

   // Arctangent of 2^-i in units of 2^-32 turn, one entry per rotation.
   localparam longint ATAN_TURNS [0:ROT_STEPS-1] = '{
      64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
      64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2E, 64'h000A2F98, 64'h000517CC,
      64'h00028BE6, 64'h000145F3, 64'h0000A2F9, 64'h0000517C, 64'h000028BE, 64'h0000145F
   };

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] sample_i;
      logic [SAMPLE_BITS-1:0] sample_q;
      logic [CHAN_BITS-1:0]   channel;
      logic                   in_chirp;
      logic                   frame_last;
   } chirp_sample_t;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [7:0]                      req_tdata = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [2*SAMPLE_BITS-1:0]        rsp_tdata;
   logic [CHAN_BITS:0]              rsp_tuser;
   logic                            rsp_tlast;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [CSR_INDEX_BITS-1:0]       csr_index = '0;
   logic [CSR_DATA_BITS-1:0]        csr_data = '0;

   // Shadow copy of the register file and of the frame sequencer.
   cfg_type                gen_cfg = '{channel_count: 3'd1, slot_samples: 16'd1,
                                       chirp_samples: 16'd1, default: '0};
   logic [COUNT_BITS-1:0]  tx_sample = '0;
   logic [CHAN_BITS-1:0]   tx_slot = '0;
   logic [PHASE_BITS-1:0]  tx_phase = '0;
   logic [PHASE_BITS-1:0]  tx_freq = '0;

   chirp_sample_t pending_samples[$];
   int            mismatch_count = 0;
   int            cycle_count = 0;
   int            send_idle_pct = 0;
   int            recv_stall_pct = 0;
   int            hold_cycles = 0;

   tdm_mimo_chirp_generator_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 8 ns clock period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog: a hung handshake or a lost sample ends the run here.
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Output side. A pending hold-off forces tready low for a counted stretch of cycles;
   // otherwise tready stalls at random with the current stall percentage.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_tready = 1'b0;
         hold_cycles = hold_cycles - 1;
      end else begin
         rsp_tready = ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Round a 2^30-scaled CORDIC output to Q1.15 (add half, floor) and saturate.
   function automatic logic [SAMPLE_BITS-1:0] round_to_q15(input longint v);
      longint r;
      r = (v + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[SAMPLE_BITS-1:0];
   endfunction

   // Cosine and sine of a phase given in turns * 2^48. The top 32 bits are the angle;
   // second and third quadrant angles are folded by a half turn and the result negated.
   function automatic void phase_to_iq(input logic [PHASE_BITS-1:0] ph,
                                       output logic [SAMPLE_BITS-1:0] ci,
                                       output logic [SAMPLE_BITS-1:0] sq);
      logic [31:0] angle;
      logic        flip;
      longint      x, y, z, dx, dy;
      angle = ph[PHASE_BITS-1 -: 32];
      flip = angle[31] ^ angle[30];
      if (flip) angle = angle - 32'h80000000;
      z = longint'($signed(angle));
      x = 652032874;
      y = 0;
      for (int i = 0; i < ROT_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - ATAN_TURNS[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + ATAN_TURNS[i];
         end
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      ci = round_to_q15(x);
      sq = round_to_q15(y);
   endfunction

   // Advances the shadow sequencer by one sample tick and returns the sample it emits.
   function automatic chirp_sample_t next_chirp_sample(input logic restart);
      chirp_sample_t s;
      int            nch, slen;
      logic          chirp, slot_end, frame_end;
      nch = int'(gen_cfg.channel_count);
      if (nch == 0) nch = 1;
      if (nch > MAX_CHANNELS) nch = MAX_CHANNELS;
      slen = int'(gen_cfg.slot_samples);
      if (slen == 0) slen = 1;
      if (restart) begin
         tx_sample = '0;
         tx_slot = '0;
         tx_phase = gen_cfg.start_phase;
         tx_freq = gen_cfg.start_freq;
      end
      chirp = (tx_sample < gen_cfg.chirp_samples);
      slot_end = (int'(tx_sample) >= slen - 1);
      frame_end = slot_end && (int'(tx_slot) >= nch - 1);
      s.sample_i = '0;
      s.sample_q = '0;
      if (chirp) phase_to_iq(tx_phase, s.sample_i, s.sample_q);
      s.channel = tx_slot;
      s.in_chirp = chirp;
      s.frame_last = frame_end;
      if (chirp) begin
         tx_phase = tx_phase + tx_freq;
         tx_freq = tx_freq + gen_cfg.freq_step;
      end
      if (slot_end) begin
         tx_sample = '0;
         tx_slot = frame_end ? '0 : tx_slot + 1'b1;
         tx_phase = gen_cfg.start_phase;
         tx_freq = gen_cfg.start_freq;
      end else begin
         tx_sample = tx_sample + 1'b1;
      end
      return s;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      mismatch_count = mismatch_count + 1;
      if (mismatch_count <= MAX_PRINTED)
         $display("mismatch at cycle %0d: %s got %0h, expected %0h",
                  cycle_count, what, got, want);
   endtask

   // Every beat taken at the output is compared with the oldest predicted sample.
   always @(posedge clock) begin
      chirp_sample_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.sample_i = rsp_tdata[SAMPLE_BITS-1:0];
         got.sample_q = rsp_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
         got.channel = rsp_tuser[CHAN_BITS-1:0];
         got.in_chirp = rsp_tuser[CHAN_BITS];
         got.frame_last = rsp_tlast;
         if (pending_samples.size() == 0) begin
            report_mismatch("beat with no sample pending", rsp_tdata, 0);
         end else begin
            want = pending_samples.pop_front();
            if (got.sample_i !== want.sample_i)
               report_mismatch("sample_i", got.sample_i, want.sample_i);
            if (got.sample_q !== want.sample_q)
               report_mismatch("sample_q", got.sample_q, want.sample_q);
            if (got.channel !== want.channel)
               report_mismatch("active_channel", got.channel, want.channel);
            if (got.in_chirp !== want.in_chirp)
               report_mismatch("in_chirp", got.in_chirp, want.in_chirp);
            if (got.frame_last !== want.frame_last)
               report_mismatch("frame_last", got.frame_last, want.frame_last);
         end
      end
   end

   // Offers one request beat, with random idle cycles ahead of it, and predicts its sample
   // once the beat is taken. tvalid stays high on return so bursts run back to back.
   task automatic send_request(input logic restart);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {7'd0, restart};
      do @(posedge clock); while (!req_tready);
      pending_samples.push_back(next_chirp_sample(restart));
   endtask

   // Drops the request valid and waits until every predicted sample has come out.
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
   endtask

   // Register writes happen only with the pipeline empty.
   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] value);
      wait_drained();
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = index;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_CHANNEL_COUNT: gen_cfg.channel_count = value[NCH_BITS-1:0];
         CSR_SLOT_SAMPLES:  gen_cfg.slot_samples = value[COUNT_BITS-1:0];
         CSR_CHIRP_SAMPLES: gen_cfg.chirp_samples = value[COUNT_BITS-1:0];
         CSR_START_PHASE:   gen_cfg.start_phase = value[PHASE_BITS-1:0];
         CSR_START_FREQ:    gen_cfg.start_freq = value[PHASE_BITS-1:0];
         CSR_FREQ_STEP:     gen_cfg.freq_step = value[PHASE_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Out of reset: one channel, one-sample slot, one-sample chirp at phase zero.
   task automatic test_power_on_defaults();
      send_request(1'b0);
      send_request(1'b1);
   endtask

   // Zero channel count, zero slot and zero chirp length, with the top phase value.
   task automatic test_zero_lengths();
      write_csr(CSR_CHANNEL_COUNT, '0);
      write_csr(CSR_SLOT_SAMPLES, '0);
      write_csr(CSR_CHIRP_SAMPLES, '0);
      write_csr(CSR_START_PHASE, '1);
      send_request(1'b1);
      send_request(1'b0);
   endtask

   // An oversized channel count clamps to four slots, and a chirp longer than the slot
   // is cut at the slot end. Then, with the frame in its third slot, the slot and
   // channel counts shrink under it, so the current sample becomes the frame's last.
   task automatic test_clamp_and_shrink();
      write_csr(CSR_CHANNEL_COUNT, 48'd7);
      write_csr(CSR_SLOT_SAMPLES, 48'd3);
      write_csr(CSR_CHIRP_SAMPLES, 48'd5);
      write_csr(CSR_START_PHASE, 48'h4000_0000_0000);
      write_csr(CSR_START_FREQ, 48'h7FFF_FFFF_FFFF);
      write_csr(CSR_FREQ_STEP, 48'h8000_0000_0000);
      send_request(1'b1);
      repeat (6) send_request(1'b0);
      write_csr(CSR_CHANNEL_COUNT, 48'd2);
      write_csr(CSR_SLOT_SAMPLES, 48'd1);
      write_csr(CSR_START_FREQ, 48'h8000_0000_0000);
      write_csr(CSR_FREQ_STEP, 48'h7FFF_FFFF_FFFF);
      repeat (3) send_request(1'b0);
   endtask

   // Longest slot and chirp, plus writes to the two unused register indexes.
   task automatic test_longest_slot();
      write_csr(CSR_CHANNEL_COUNT, 48'd4);
      write_csr(CSR_SLOT_SAMPLES, 48'hFFFF);
      write_csr(CSR_CHIRP_SAMPLES, 48'hFFFF);
      write_csr(CSR_START_PHASE, 48'({$urandom, $urandom}));
      write_csr(CSR_SPARE_LO, '1);
      write_csr(CSR_SPARE_HI, 48'({$urandom, $urandom}));
      send_request(1'b1);
      repeat (5) send_request(1'b0);
   endtask

   // A fresh setting: mostly short slots so frames wrap often, now and then a long one.
   // Frequencies are either full-range or small, which gives slowly swept chirps.
   task automatic write_random_setup(input bit write_all);
      int          slot_len, chirp_len;
      logic [31:0] rnd;
      slot_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 65535)
                                             : $urandom_range(0, 12);
      case ($urandom_range(0, 3))
         0:       chirp_len = 0;
         1:       chirp_len = $urandom_range(0, slot_len);
         2:       chirp_len = (slot_len + $urandom_range(1, 5) > 65535) ? 65535
                                                                       : slot_len + 3;
         default: chirp_len = $urandom_range(0, 65535);
      endcase
      if (write_all || $urandom_range(0, 2) != 0)
         write_csr(CSR_CHANNEL_COUNT, 48'($urandom_range(0, 7)));
      if (write_all || $urandom_range(0, 2) != 0)
         write_csr(CSR_SLOT_SAMPLES, 48'(slot_len));
      if (write_all || $urandom_range(0, 2) != 0)
         write_csr(CSR_CHIRP_SAMPLES, 48'(chirp_len));
      if (write_all || $urandom_range(0, 2) != 0)
         write_csr(CSR_START_PHASE, 48'({$urandom, $urandom}));
      rnd = $urandom;
      if (write_all || $urandom_range(0, 2) != 0)
         write_csr(CSR_START_FREQ, $urandom_range(0, 1) ? 48'({$urandom, $urandom})
                                                        : {{20{rnd[27]}}, rnd[27:0]});
      rnd = $urandom;
      if (write_all || $urandom_range(0, 2) != 0)
         write_csr(CSR_FREQ_STEP, $urandom_range(0, 1) ? 48'({$urandom, $urandom})
                                                       : {{28{rnd[19]}}, rnd[19:0]});
      if ($urandom_range(0, 7) == 0)
         write_csr($urandom_range(0, 1) ? CSR_SPARE_LO : CSR_SPARE_HI,
                   48'({$urandom, $urandom}));
   endtask

   // Random frames: bursts of samples with occasional restarts, a new setting between
   // bursts. Settings are partly rewritten, so some changes land in the middle of a frame.
   task automatic test_random_frames(input int count, input int idle_pct, input int stall_pct);
      int sent;
      sent = 0;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      write_random_setup(1'b1);
      while (sent < count) begin
         repeat ($urandom_range(10, 40)) begin
            send_request($urandom_range(0, 15) == 0);
            sent = sent + 1;
         end
         write_random_setup(1'b0);
      end
      wait_drained();
   endtask

   // The output holds off for a long stretch while requests keep coming, so the
   // pipeline fills and the core must stall its request side.
   task automatic test_output_hold_off();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      send_request(1'b1);
      hold_cycles = 300;
      repeat (40) send_request(1'b0);
      wait_drained();
   endtask

   // The sender stops until the pipeline is empty, then resumes mid-frame.
   task automatic test_sender_pause();
      send_idle_pct = 0;
      recv_stall_pct = 62;
      repeat (20) send_request($urandom_range(0, 15) == 0);
      wait_drained();
      repeat (20) send_request(1'b0);
      wait_drained();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_power_on_defaults();
      test_zero_lengths();
      test_clamp_and_shrink();
      test_longest_slot();
      test_random_frames(150, 0, 0);
      test_random_frames(150, 62, 0);
      test_random_frames(150, 0, 62);
      test_random_frames(150, 15, 15);
      test_output_hold_off();
      test_sender_pause();

      // Let any stray beat show up after the last expected sample.
      recv_stall_pct = 0;
      wait_drained();
      repeat (2 * PIPE_DEPTH) @(posedge clock);
      if (mismatch_count == 0 && pending_samples.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
